// ===== sv/sgod_pkg.sv =====
// Shared types and constants of the simple glyph outline decoder.
package sgod_pkg;

  // Default point store depth
  localparam int unsigned MaxPointsDef = 1024;

  // Stream widths
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned KindW     = 3;

  // Payload field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 15;
  localparam int unsigned ValueW = 17;
  localparam int unsigned IndexW = 16;

  // Output tdata bit positions
  localparam int unsigned ValueLsb  = 0;
  localparam int unsigned IndexLsb  = 17;
  localparam int unsigned RepeatLsb = 33;

  // Flag byte bit positions
  localparam int unsigned XShortBit = 1;
  localparam int unsigned YShortBit = 2;
  localparam int unsigned RepeatBit = 3;
  localparam int unsigned XSameBit  = 4;
  localparam int unsigned YSameBit  = 5;

  typedef enum logic [KindW-1:0] {
    KIND_END_POINT  = 3'd0,
    KIND_INSTR_LEN  = 3'd1,
    KIND_INSTR_BYTE = 3'd2,
    KIND_FLAG       = 3'd3,
    KIND_X_DELTA    = 3'd4,
    KIND_Y_DELTA    = 3'd5,
    KIND_ERROR      = 3'd6
  } item_kind_e;

endpackage

// ===== sv/simple_glyph_outline_decoder_top.sv =====
// Simple glyph outline decoder: byte stream in, decoded outline items out.
//
// Input channel (s_axis): one glyph body byte per item, big-endian fields.
// tuser marks the first byte of a glyph; contour_count is sampled with it.
// Output channel (m_axis): one decoded item per result (end point, instruction
// length, instruction byte, flag with repeat count, X delta, Y delta, error);
// tlast marks the final item of the glyph.
//
// Timing: header and instruction bytes are taken while the receiver does not
// stall, and their item shows in the output register on the next cycle. A
// flag byte is written into the flag store; a repeat byte then writes the
// expanded flags into the flag store one entry per cycle. After the final
// flag and after each coordinate, a forward scan over the flag store finds
// the next point that reads bytes, one stored flag per cycle. No input byte is
// taken during the fill or the scan. The flag store has one write port and one
// registered read port. Writes and scan reads never overlap, so no
// forwarding is needed.
//
// Reset clears all control state and leaves the flag store undefined; only
// entries written for the current glyph are ever read. While the receiver
// stalls, the output register holds its item and no new input item is taken.
module simple_glyph_outline_decoder_top
  import sgod_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: data_byte[7:0], contour_count[22:8], zero pad[23]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // tuser: glyph_start
  input  logic                 s_axis_tuser_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: value[16:0], item_index[32:17], repeat_count[40:33], zero pad[47:41]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // tuser: item_kind
  output logic [KindW-1:0]     m_axis_tuser_o,
  output logic                 m_axis_tlast_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned PW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = ((PW > ByteW) ? PW : ByteW) + 1;

  // Decoder phases plus the two store-sweep states
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ENDPTS = 10'b0000000010,
    S_ILEN   = 10'b0000000100,
    S_INSTR  = 10'b0000001000,
    S_FLAGS  = 10'b0000010000,
    S_REPEAT = 10'b0000100000,
    S_XC     = 10'b0001000000,
    S_YC     = 10'b0010000000,
    S_FILL   = 10'b0100000000,
    S_SCAN   = 10'b1000000000
  } state_e;

  // True when a flag reads coordinate bytes on the given axis
  function automatic logic reads_bytes(input logic [ByteW-1:0] f, input logic on_y);
    reads_bytes = on_y ? (f[YShortBit] || !f[YSameBit]) : (f[XShortBit] || !f[XSameBit]);
  endfunction

  // Input fields
  logic [ByteW-1:0]  din_byte;
  logic [CountW-1:0] din_cc;
  logic              din_start;
  assign din_byte  = s_axis_tdata_i[ByteW-1:0];
  assign din_cc    = s_axis_tdata_i[ByteW+CountW-1:ByteW];
  assign din_start = s_axis_tuser_i;

  // Control and datapath registers
  state_e            state_q, state_d;
  logic              bp_q, bp_d;
  logic [ByteW-1:0]  high_q, high_d;
  logic [IndexW-1:0] field_cnt_q, field_cnt_d;
  logic [CountW-1:0] ce_q, ce_d;
  logic [IndexW-1:0] rem_q, rem_d;
  logic [PW-1:0]     pts_q, pts_d;
  logic [PW-1:0]     filled_q, filled_d;
  logic [ByteW-1:0]  held_q, held_d;
  logic [PW-1:0]     coord_q, coord_d;
  logic [ByteW-1:0]  cur_flag_q, cur_flag_d;
  logic [PW-1:0]     fill_ptr_q, fill_ptr_d;
  logic [PW-1:0]     scan_ptr_q, scan_ptr_d;
  logic [PW-1:0]     chk_ptr_q, chk_ptr_d;
  logic              chk_vld_q, chk_vld_d;
  logic              scan_y_q, scan_y_d;

  // Item waiting for a sweep to finish
  item_kind_e        pend_kind_q, pend_kind_d;
  logic [ValueW-1:0] pend_val_q, pend_val_d;
  logic [IndexW-1:0] pend_idx_q, pend_idx_d;
  logic [ByteW-1:0]  pend_rep_q, pend_rep_d;

  // Output register
  logic              m_vld_q;
  item_kind_e        m_kind_q;
  logic [ValueW-1:0] m_val_q;
  logic [IndexW-1:0] m_idx_q;
  logic [ByteW-1:0]  m_rep_q;
  logic              m_last_q;

  logic              out_load;
  item_kind_e        out_kind;
  logic [ValueW-1:0] out_val;
  logic [IndexW-1:0] out_idx;
  logic [ByteW-1:0]  out_rep;
  logic              out_last;

  // Flag store
  logic [ByteW-1:0]  flag_mem [MAX_POINTS];
  logic [ByteW-1:0]  rd_data_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ByteW-1:0]  mem_wdata;

  logic              out_free;
  logic              busy;
  logic              s_fire;
  logic [IndexW-1:0] word;
  logic              on_y;
  logic              short_b;
  logic              pos_b;
  logic [SW-1:0]     rep_sum;
  logic              found;

  assign out_free        = !m_vld_q || m_axis_tready_i;
  assign busy            = (state_q == S_FILL) || (state_q == S_SCAN);
  assign s_axis_tready_o = !busy && out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign word            = {high_q, din_byte};
  assign on_y            = (state_q == S_YC);
  assign short_b         = on_y ? cur_flag_q[YShortBit] : cur_flag_q[XShortBit];
  assign pos_b           = on_y ? cur_flag_q[YSameBit] : cur_flag_q[XSameBit];
  assign rep_sum         = SW'(filled_q) + SW'(1) + SW'(din_byte);
  assign found           = chk_vld_q && reads_bytes(rd_data_q, scan_y_q);

  always_comb begin
    state_d     = state_q;
    bp_d        = bp_q;
    high_d      = high_q;
    field_cnt_d = field_cnt_q;
    ce_d        = ce_q;
    rem_d       = rem_q;
    pts_d       = pts_q;
    filled_d    = filled_q;
    held_d      = held_q;
    coord_d     = coord_q;
    cur_flag_d  = cur_flag_q;
    fill_ptr_d  = fill_ptr_q;
    scan_ptr_d  = scan_ptr_q;
    chk_ptr_d   = chk_ptr_q;
    chk_vld_d   = chk_vld_q;
    scan_y_d    = scan_y_q;
    pend_kind_d = pend_kind_q;
    pend_val_d  = pend_val_q;
    pend_idx_d  = pend_idx_q;
    pend_rep_d  = pend_rep_q;
    mem_we      = 1'b0;
    mem_waddr   = filled_q[AW-1:0];
    mem_wdata   = din_byte;
    out_load    = 1'b0;
    out_kind    = pend_kind_q;
    out_val     = pend_val_q;
    out_idx     = pend_idx_q;
    out_rep     = pend_rep_q;
    out_last    = 1'b0;

    if (s_fire) begin
      if (din_start) begin
        // Abandon any glyph in flight; with contours, this byte is the first end point's high byte
        field_cnt_d = '0;
        pts_d       = '0;
        filled_d    = '0;
        coord_d     = '0;
        if (din_cc == '0) begin
          state_d  = S_IDLE;
          bp_d     = 1'b0;
          out_load = 1'b1;
          out_kind = KIND_ERROR;
          out_val  = '0;
          out_idx  = '0;
          out_rep  = '0;
          out_last = 1'b1;
        end else begin
          ce_d    = din_cc;
          high_d  = din_byte;
          bp_d    = 1'b1;
          state_d = S_ENDPTS;
        end
      end else begin
        unique case (state_q)
          S_ENDPTS: begin
            if (!bp_q) begin
              high_d = din_byte;
              bp_d   = 1'b1;
            end else begin
              bp_d     = 1'b0;
              out_load = 1'b1;
              out_kind = KIND_END_POINT;
              out_val  = ValueW'(word);
              out_idx  = field_cnt_q;
              out_rep  = '0;
              if ({1'b0, field_cnt_q} + 17'd1 < {2'b00, ce_q}) begin
                field_cnt_d = field_cnt_q + IndexW'(1);
              end else if ({1'b0, word} >= 17'(MAX_POINTS)) begin
                // Point count over capacity: error replaces the end point
                state_d  = S_IDLE;
                out_kind = KIND_ERROR;
                out_last = 1'b1;
              end else begin
                pts_d       = PW'({1'b0, word} + 17'd1);
                field_cnt_d = '0;
                state_d     = S_ILEN;
              end
            end
          end
          S_ILEN: begin
            if (!bp_q) begin
              high_d = din_byte;
              bp_d   = 1'b1;
            end else begin
              bp_d        = 1'b0;
              rem_d       = word;
              field_cnt_d = '0;
              filled_d    = '0;
              state_d     = (word != '0) ? S_INSTR : S_FLAGS;
              out_load    = 1'b1;
              out_kind    = KIND_INSTR_LEN;
              out_val     = ValueW'(word);
              out_idx     = '0;
              out_rep     = '0;
            end
          end
          S_INSTR: begin
            field_cnt_d = field_cnt_q + IndexW'(1);
            rem_d       = rem_q - IndexW'(1);
            if (rem_q == IndexW'(1)) begin
              state_d = S_FLAGS;
            end
            out_load = 1'b1;
            out_kind = KIND_INSTR_BYTE;
            out_val  = ValueW'(din_byte);
            out_idx  = field_cnt_q;
            out_rep  = '0;
          end
          S_FLAGS: begin
            mem_we      = 1'b1;
            held_d      = din_byte;
            pend_kind_d = KIND_FLAG;
            pend_val_d  = ValueW'(din_byte);
            pend_idx_d  = IndexW'(filled_q);
            pend_rep_d  = '0;
            if (din_byte[RepeatBit]) begin
              state_d = S_REPEAT;
            end else begin
              filled_d   = filled_q + PW'(1);
              fill_ptr_d = filled_q + PW'(1);
              state_d    = S_FILL;
            end
          end
          S_REPEAT: begin
            // Drop expanded flags past the point count
            filled_d   = (rep_sum > SW'(pts_q)) ? pts_q : PW'(rep_sum);
            fill_ptr_d = filled_q + PW'(1);
            pend_rep_d = din_byte;
            state_d    = S_FILL;
          end
          S_XC, S_YC: begin
            if (!short_b && !bp_q) begin
              high_d = din_byte;
              bp_d   = 1'b1;
            end else begin
              bp_d        = 1'b0;
              pend_kind_d = on_y ? KIND_Y_DELTA : KIND_X_DELTA;
              pend_idx_d  = IndexW'(coord_q);
              pend_rep_d  = '0;
              if (short_b) begin
                pend_val_d = pos_b ? {9'b0, din_byte} : -{9'b0, din_byte};
              end else begin
                pend_val_d = {high_q[ByteW-1], high_q, din_byte};
              end
              // Look for the next point that reads bytes on this axis
              scan_ptr_d = coord_q + PW'(1);
              scan_y_d   = on_y;
              chk_vld_d  = 1'b0;
              state_d    = S_SCAN;
            end
          end
          default: begin
            // Idle padding without a glyph start: drop
          end
        endcase
      end
    end else begin
      unique case (state_q)
        S_FILL: begin
          if (fill_ptr_q < filled_q) begin
            mem_we     = 1'b1;
            mem_waddr  = fill_ptr_q[AW-1:0];
            mem_wdata  = held_q;
            fill_ptr_d = fill_ptr_q + PW'(1);
          end else if (filled_q < pts_q) begin
            state_d  = S_FLAGS;
            out_load = 1'b1;
          end else begin
            scan_ptr_d = '0;
            scan_y_d   = 1'b0;
            chk_vld_d  = 1'b0;
            state_d    = S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            coord_d    = chk_ptr_q;
            cur_flag_d = rd_data_q;
            chk_vld_d  = 1'b0;
            state_d    = scan_y_q ? S_YC : S_XC;
            out_load   = 1'b1;
          end else if (scan_ptr_q < pts_q) begin
            chk_ptr_d  = scan_ptr_q;
            chk_vld_d  = 1'b1;
            scan_ptr_d = scan_ptr_q + PW'(1);
          end else if (!scan_y_q) begin
            // X axis done: restart on Y from the first point
            scan_y_d   = 1'b1;
            scan_ptr_d = '0;
            chk_vld_d  = 1'b0;
          end else begin
            chk_vld_d = 1'b0;
            state_d   = S_IDLE;
            out_load  = 1'b1;
            out_last  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bp_q        <= 1'b0;
      high_q      <= '0;
      field_cnt_q <= '0;
      ce_q        <= '0;
      rem_q       <= '0;
      pts_q       <= '0;
      filled_q    <= '0;
      held_q      <= '0;
      coord_q     <= '0;
      cur_flag_q  <= '0;
      fill_ptr_q  <= '0;
      scan_ptr_q  <= '0;
      chk_ptr_q   <= '0;
      chk_vld_q   <= 1'b0;
      scan_y_q    <= 1'b0;
      m_vld_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      bp_q        <= bp_d;
      high_q      <= high_d;
      field_cnt_q <= field_cnt_d;
      ce_q        <= ce_d;
      rem_q       <= rem_d;
      pts_q       <= pts_d;
      filled_q    <= filled_d;
      held_q      <= held_d;
      coord_q     <= coord_d;
      cur_flag_q  <= cur_flag_d;
      fill_ptr_q  <= fill_ptr_d;
      scan_ptr_q  <= scan_ptr_d;
      chk_ptr_q   <= chk_ptr_d;
      chk_vld_q   <= chk_vld_d;
      scan_y_q    <= scan_y_d;
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    pend_val_q  <= pend_val_d;
    pend_idx_q  <= pend_idx_d;
    pend_rep_q  <= pend_rep_d;
    if (out_load) begin
      m_kind_q <= out_kind;
      m_val_q  <= out_val;
      m_idx_q  <= out_idx;
      m_rep_q  <= out_rep;
      m_last_q <= out_last;
    end
  end

  // Flag store: one write port, one registered read port driven by the scan pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flag_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= flag_mem[scan_ptr_q[AW-1:0]];
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {7'b0, m_rep_q, m_idx_q, m_val_q};

endmodule

// ===== sv/sgod_checker.sv =====
// Port-level assertions for the simple glyph outline decoder, bound to the top level.
module sgod_checker
  import sgod_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic [InTdataW-1:0]  s_axis_tdata_i,
  input logic                 s_axis_tuser_i,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic [KindW-1:0]     m_axis_tuser_o,
  input logic                 m_axis_tlast_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i
);

  // A stalled item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // No new input item while a result waits in a stalled output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // An error item always closes the glyph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_ERROR) |-> m_axis_tlast_o)
    else $error("error item without last");

  // Repeat count is zero on every item but a flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != KIND_FLAG) |->
      (m_axis_tdata_o[RepeatLsb+ByteW-1:RepeatLsb] == '0))
    else $error("nonzero repeat on a non-flag item");

  // A glyph start with no contours yields an error item on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i
      && (s_axis_tdata_i[ByteW+CountW-1:ByteW] == '0) |=>
      m_axis_tvalid_o && (m_axis_tuser_o == KIND_ERROR) && m_axis_tlast_o)
    else $error("zero contour count not reported");

endmodule

bind simple_glyph_outline_decoder_top sgod_checker u_sgod_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

// ===== tb/simple_glyph_outline_decoder_top_tb.sv =====
// Self-checking testbench of the simple glyph outline decoder on its byte and item streams.
`timescale 1ns / 100ps

module simple_glyph_outline_decoder_top_tb;
  import sgod_pkg::*;

  localparam int unsigned MaxPts = MaxPointsDef;

  // Flag byte masks of a simple glyph
  localparam logic [7:0] FlagXShort = 8'h1 << XShortBit;
  localparam logic [7:0] FlagYShort = 8'h1 << YShortBit;
  localparam logic [7:0] FlagRepeat = 8'h1 << RepeatBit;
  localparam logic [7:0] FlagXSame  = 8'h1 << XSameBit;
  localparam logic [7:0] FlagYSame  = 8'h1 << YSameBit;

  // One decoded outline item as it leaves the block
  typedef struct packed {
    item_kind_e   kind;
    logic [16:0]  value;
    logic [15:0]  item_idx;
    logic [7:0]   rep_count;
    logic         last;
  } outline_item_t;

  // One byte of a glyph body with its sideband
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [14:0] cc;
  } glyph_byte_t;

  // Glyph parser mirror: tracks the decode state and keeps the outline items still owed.
  class glyph_scoreboard;
    typedef enum logic [2:0] {
      PS_IDLE, PS_END_PTS, PS_INSTR_LEN, PS_INSTR, PS_FLAGS, PS_REPEAT, PS_X_COORD, PS_Y_COORD
    } parse_state_e;

    parse_state_e  state;
    int unsigned   field_cnt, contours_exp, last_end, instr_left;
    int unsigned   points_total, flags_filled, coord_ptr;
    logic [7:0]    held_flag, high_byte;
    bit            byte_phase;
    bit [7:0]      flag_mem [MaxPts];
    outline_item_t owed_q [$];
    int unsigned   errors, checked;

    function new();
      state        = PS_IDLE;
      field_cnt    = 0;
      contours_exp = 0;
      last_end     = 0;
      instr_left   = 0;
      points_total = 0;
      flags_filled = 0;
      coord_ptr    = 0;
      held_flag    = '0;
      high_byte    = '0;
      byte_phase   = 1'b0;
      errors       = 0;
      checked      = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void owe(item_kind_e k, logic [16:0] v, int unsigned idx, logic [7:0] rep,
                      bit last);
      outline_item_t it;
      it.kind      = k;
      it.value     = v;
      it.item_idx  = 16'(idx);
      it.rep_count = rep;
      it.last      = last;
      owed_q.push_back(it);
    endfunction

    // First point at or after from whose flag reads bytes on this axis
    function int unsigned next_coded(int unsigned from, logic [7:0] short_mask,
                                     logic [7:0] same_mask);
      for (int unsigned i = from; i < points_total && i < MaxPts; i++) begin
        if ((flag_mem[i] & short_mask) != 0 || (flag_mem[i] & same_mask) == 0) return i;
      end
      return points_total;
    endfunction

    // Move to the next coordinate that reads bytes; 0 once the glyph is done
    function bit seek_coord(bit on_y, int unsigned from);
      int unsigned p;
      byte_phase = 1'b0;
      if (!on_y) begin
        p = next_coded(from, FlagXShort, FlagXSame);
        if (p < points_total) begin
          state     = PS_X_COORD;
          coord_ptr = p;
          return 1'b1;
        end
        from = 0;
      end
      p = next_coded(from, FlagYShort, FlagYSame);
      if (p < points_total) begin
        state     = PS_Y_COORD;
        coord_ptr = p;
        return 1'b1;
      end
      state = PS_IDLE;
      return 1'b0;
    endfunction

    function void close_flag(int unsigned idx, logic [7:0] rep);
      bit more;
      if (flags_filled < points_total) begin
        state = PS_FLAGS;
        owe(KIND_FLAG, 17'(held_flag), idx, rep, 1'b0);
      end else begin
        more = seek_coord(1'b0, 0);
        owe(KIND_FLAG, 17'(held_flag), idx, rep, !more);
      end
    endfunction

    // Advance the parser by one accepted byte
    function void note_byte(logic [7:0] b, logic start, logic [14:0] cc);
      int unsigned v, idx;
      logic [7:0]  f, sb, pb;
      logic [15:0] raw;
      logic [16:0] d;
      bit          more, on_y;
      if (start) begin
        field_cnt    = 0;
        points_total = 0;
        flags_filled = 0;
        coord_ptr    = 0;
        if (cc == 0) begin
          state      = PS_IDLE;
          byte_phase = 1'b0;
          owe(KIND_ERROR, '0, 0, '0, 1'b1);
          return;
        end
        contours_exp = cc;
        high_byte    = b;
        byte_phase   = 1'b1;
        state        = PS_END_PTS;
        return;
      end
      case (state)
        PS_END_PTS: begin
          if (!byte_phase) begin
            high_byte  = b;
            byte_phase = 1'b1;
            return;
          end
          byte_phase = 1'b0;
          v          = {high_byte, b};
          idx        = field_cnt;
          last_end   = v;
          if (idx + 1 < contours_exp) begin
            field_cnt = idx + 1;
            owe(KIND_END_POINT, 17'(v), idx, '0, 1'b0);
          end else if (v + 1 > MaxPts) begin
            state = PS_IDLE;
            owe(KIND_ERROR, 17'(v), idx, '0, 1'b1);
          end else begin
            points_total = v + 1;
            field_cnt    = 0;
            state        = PS_INSTR_LEN;
            owe(KIND_END_POINT, 17'(v), idx, '0, 1'b0);
          end
        end
        PS_INSTR_LEN: begin
          if (!byte_phase) begin
            high_byte  = b;
            byte_phase = 1'b1;
            return;
          end
          byte_phase   = 1'b0;
          v            = {high_byte, b};
          instr_left   = v;
          field_cnt    = 0;
          flags_filled = 0;
          state        = (v != 0) ? PS_INSTR : PS_FLAGS;
          owe(KIND_INSTR_LEN, 17'(v), 0, '0, 1'b0);
        end
        PS_INSTR: begin
          idx        = field_cnt;
          field_cnt  = (field_cnt + 1) & 16'hFFFF;
          instr_left = (instr_left - 1) & 16'hFFFF;
          if (instr_left == 0) state = PS_FLAGS;
          owe(KIND_INSTR_BYTE, 17'(b), idx, '0, 1'b0);
        end
        PS_FLAGS: begin
          idx       = flags_filled;
          held_flag = b;
          if (idx < points_total && idx < MaxPts) flag_mem[idx] = b;
          if ((b & FlagRepeat) != 0) begin
            state = PS_REPEAT;
            return;
          end
          flags_filled = idx + 1;
          close_flag(idx, '0);
        end
        PS_REPEAT: begin
          idx = flags_filled;
          for (int unsigned k = 1; k <= b && idx + k < points_total && idx + k < MaxPts; k++)
            flag_mem[idx + k] = held_flag;
          flags_filled = idx + 1 + b;
          if (flags_filled > points_total) flags_filled = points_total;
          close_flag(idx, b);
        end
        PS_X_COORD, PS_Y_COORD: begin
          idx  = coord_ptr;
          f    = (idx < MaxPts) ? flag_mem[idx] : 8'h00;
          on_y = (state == PS_Y_COORD);
          sb   = on_y ? FlagYShort : FlagXShort;
          pb   = on_y ? FlagYSame : FlagXSame;
          if ((f & sb) == 0 && !byte_phase) begin
            high_byte  = b;
            byte_phase = 1'b1;
            return;
          end
          if ((f & sb) != 0) begin
            d = ((f & pb) != 0) ? {9'd0, b} : 17'd0 - {9'd0, b};
          end else begin
            raw = {high_byte, b};
            d   = {raw[15], raw};
          end
          more = seek_coord(on_y, idx + 1);
          owe(on_y ? KIND_Y_DELTA : KIND_X_DELTA, d, idx, '0, !more);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t, result %0d: %s", $realtime, checked, msg);
      errors++;
    endtask

    // Compare one accepted item with the oldest one owed
    task check_item(logic [2:0] kind, logic [16:0] value, logic [15:0] idx,
                    logic [7:0] rep, logic last);
      outline_item_t want;
      checked++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d value %0h", kind, value));
        return;
      end
      want = owed_q.pop_front();
      if (kind != want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      if (value != want.value)
        report_mismatch($sformatf("value %0h, want %0h", value, want.value));
      if (idx != want.item_idx)
        report_mismatch($sformatf("index %0d, want %0d", idx, want.item_idx));
      if (rep != want.rep_count)
        report_mismatch($sformatf("repeat %0d, want %0d", rep, want.rep_count));
      if (last != want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

  // Clock, reset and DUT ports; every input known from time zero
  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic [KindW-1:0]     m_axis_tuser_o;
  logic                 m_axis_tlast_o;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;

  glyph_scoreboard sb;
  glyph_byte_t     stim_q [$];
  logic [7:0]      point_flags [MaxPts];  // expanded flags of the glyph being built
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;

  simple_glyph_outline_decoder_top #(
    .MAX_POINTS(MaxPts)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the receiver at the rate of the current traffic phase
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every item the receiver takes; values sampled here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_item(m_axis_tuser_o, m_axis_tdata_o[ValueLsb +: ValueW],
                    m_axis_tdata_o[IndexLsb +: IndexW], m_axis_tdata_o[RepeatLsb +: ByteW],
                    m_axis_tlast_o);
  end

  // Queue the first byte of a glyph body with its contour count
  function automatic void add_start(logic [7:0] data, logic [14:0] cc);
    glyph_byte_t it;
    it.data  = data;
    it.start = 1'b1;
    it.cc    = cc;
    stim_q.push_back(it);
  endfunction

  // Queue a body byte; the contour count is noise here and must be ignored
  function automatic void add_byte(logic [7:0] data);
    glyph_byte_t it;
    it.data  = data;
    it.start = 1'b0;
    it.cc    = 15'($urandom);
    stim_q.push_back(it);
  endfunction

  // Append one glyph: mostly well-formed bodies with random content, plus zero-contour
  // starts, over-capacity end points, garbage that the next start abandons, truncated
  // bodies and trailing padding.
  task automatic build_glyph();
    int unsigned mode, n_cont, n_pts, i_len, filled, rep, base, cut;
    logic [15:0] word;
    logic [7:0]  fl;
    bit          big, over_cap;
    base = stim_q.size();
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      add_start(8'($urandom), '0);
    end else if (mode < 13) begin
      // random contour count reaches every bit of the field; the body is random bytes
      add_start(8'($urandom), 15'($urandom));
      repeat ($urandom_range(0, 12)) add_byte(8'($urandom));
    end else begin
      over_cap = (mode < 21);
      big      = ($urandom_range(0, 99) < 2);
      n_cont   = $urandom_range(1, 4);
      if (over_cap)
        n_pts = $urandom_range(0, 1) ? MaxPts + 1 : $urandom_range(MaxPts + 1, 65536);
      else if (big)
        n_pts = $urandom_range(0, 3) == 0 ? MaxPts : $urandom_range(200, MaxPts);
      else
        n_pts = $urandom_range(1, 24);
      for (int unsigned c = 0; c < n_cont; c++) begin
        word = (c == n_cont - 1) ? 16'(n_pts - 1) : 16'($urandom);
        if (c == 0) add_start(word[15:8], 15'(n_cont));
        else add_byte(word[15:8]);
        add_byte(word[7:0]);
      end
      if (!over_cap) begin
        i_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        add_byte(8'(i_len >> 8));
        add_byte(8'(i_len));
        repeat (i_len) add_byte(8'($urandom));
        filled = 0;
        while (filled < n_pts) begin
          fl = 8'($urandom);
          // big glyphs lean on long runs of repeated flags that read no coordinates
          if (big && $urandom_range(0, 9) != 0)
            fl = (fl & 8'hC1) | FlagRepeat | FlagXSame | FlagYSame;
          add_byte(fl);
          rep = 0;
          if ((fl & FlagRepeat) != 0) begin
            if (big || $urandom_range(0, 9) == 0) rep = $urandom_range(0, 255);
            else rep = $urandom_range(0, 4);
            add_byte(8'(rep));
          end
          for (int unsigned k = 0; k <= rep && filled < n_pts; k++) begin
            point_flags[filled] = fl;
            filled++;
          end
        end
        for (int unsigned p = 0; p < n_pts; p++) begin
          if ((point_flags[p] & FlagXShort) != 0) add_byte(8'($urandom));
          else if ((point_flags[p] & FlagXSame) == 0) repeat (2) add_byte(8'($urandom));
        end
        for (int unsigned p = 0; p < n_pts; p++) begin
          if ((point_flags[p] & FlagYShort) != 0) add_byte(8'($urandom));
          else if ((point_flags[p] & FlagYSame) == 0) repeat (2) add_byte(8'($urandom));
        end
      end
      // cut some bodies short; the next start abandons them
      if (mode < 33 && stim_q.size() - base > 1) begin
        cut = $urandom_range(1, stim_q.size() - base - 1);
        while (stim_q.size() > base + cut) void'(stim_q.pop_back());
      end
    end
    if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
  endtask

  // Offer one item, idling first at the sender rate, and note it once accepted
  task automatic send_item(glyph_byte_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, it.cc, it.data};
    s_axis_tuser_i  <= it.start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_byte(it.data, it.start, it.cc);
  endtask

  task automatic send_queued();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
  endtask

  // Hold the sender until every owed item has come out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    sb            = new();
    send_idle_pct = 34;
    recv_idle_pct = 67;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: padding while idle, zero contours, then short glyphs that cover
    // every item kind, the word extremes, negated shorts, a skipped Y axis and a
    // glyph whose flags read no coordinates at all.
    add_byte(8'hFF);
    add_start(8'h5A, 15'd0);
    add_start(8'h00, 15'd1);               // one contour, end point 2
    add_byte(8'h02);
    add_byte(8'h00);                       // instruction length 1
    add_byte(8'h01);
    add_byte(8'hA5);
    add_byte(FlagRepeat | FlagXShort | FlagXSame | FlagYSame);
    add_byte(8'h01);                       // points 0 and 1
    add_byte(8'h00);                       // point 2 reads words on both axes
    add_byte(8'hFF);
    add_byte(8'h01);
    add_byte(8'h80);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte(8'hFF);
    add_start(8'h00, 15'd1);               // one point, negated short X, Y same
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(FlagXShort | FlagYSame);
    add_byte(8'h80);
    add_start(8'h00, 15'd1);               // one point with nothing to read
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(FlagXSame | FlagYSame);
    send_queued();
    drain();

    // Random traffic in three phases: receiver stalls most, then sender idles most,
    // then nothing idles. Each phase ends with a full drain of the output.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 34 : 0;
      sent = 0;
      while (sent < 284) begin
        build_glyph();
        sent += stim_q.size();
        send_queued();
      end
      drain();
    end

    // Let any scan or repeat expansion still running show a stray item
    repeat (1200) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d items never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== simple_glyph_outline_decoder_top.f =====
sv/sgod_pkg.sv
sv/simple_glyph_outline_decoder_top.sv
sv/sgod_checker.sv
tb/simple_glyph_outline_decoder_top_tb.sv
